>>> src/lstras_pkg.sv
// ----------------------------------------------------------------------------
// lstras_pkg
// Shared constants and types for the range-add / range-sum tree block.
// ----------------------------------------------------------------------------
package lstras_pkg;

  localparam int unsigned LEAVES_DEF = 1024;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned IDX_W      = 11;
  localparam int unsigned CMD_W      = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SUM   = 2'd2;

  // one memory word holds both indexed-tree entries of an element
  typedef struct packed {
    logic [DATA_W-1:0] b1;
    logic [DATA_W-1:0] b2;
  } tree_word_t;

endpackage

>>> src/lstras_mem.sv
// ----------------------------------------------------------------------------
// lstras_mem
// Single write, single read memory of tree words, registered read data.
// ----------------------------------------------------------------------------
module lstras_mem
  import lstras_pkg::*;
#(
  parameter int unsigned AW = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  tree_word_t    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output tree_word_t    rdata_o
);

  tree_word_t mem [2**AW];
  tree_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/lstras_mul.sv
// ----------------------------------------------------------------------------
// lstras_mul
// 64-bit by index multiply modulo 2^64, two 32-bit halves: low half product registered, then summed.
// ----------------------------------------------------------------------------
module lstras_mul
  import lstras_pkg::*;
#(
  parameter int unsigned BW = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] a_i,
  input  logic [BW-1:0]     b_i,
  output logic              done_o,
  output logic [DATA_W-1:0] p_o
);

  logic [DATA_W-1:0] a_q;
  logic [BW-1:0]     b_q;
  logic [32+BW-1:0]  lo_q;
  logic [32+BW-1:0]  hi_prod;
  logic [DATA_W-1:0] p_q;
  logic              ph1_q, ph2_q, done_q;

  assign hi_prod = a_q[63:32] * b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph1_q  <= 1'b0;
      ph2_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      ph1_q  <= start_i;
      ph2_q  <= ph1_q;
      done_q <= ph2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (ph1_q) begin
      lo_q <= a_q[31:0] * b_q;
    end
    if (ph2_q) begin
      p_q <= DATA_W'(lo_q) + {hi_prod[31:0], 32'b0};
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

>>> src/lazy_segment_tree_range_add_sum.sv
// ----------------------------------------------------------------------------
// lazy_segment_tree_range_add_sum
// Range add / range sum over LEAVES signed 64-bit elements, kept as two
// indexed trees in one memory; prefix(x) = x*S1(x) - S2(x).
// ----------------------------------------------------------------------------
//  channel | signals                                           | dir
//  in      | in_valid_i in_ready_o command_i left_index_i       | in
//          | right_index_i addend_i                            |
//  out     | out_valid_o out_ready_i range_sum_o               | out
//
// one item at a time; an add takes two multiplies and two read-modify-write
// walks, each visiting log2(LEAVES)+1 entries at most
// a query takes at most two prefix walks, each followed by a multiply
// clear and reset both sweep every memory entry, input not ready
// a stalled result holds the block until taken
// ----------------------------------------------------------------------------
module lazy_segment_tree_range_add_sum
  import lstras_pkg::*;
#(
  parameter int unsigned LEAVES = LEAVES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [IDX_W-1:0]  left_index_i,
  input  logic [IDX_W-1:0]  right_index_i,
  input  logic [DATA_W-1:0] addend_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] range_sum_o
);

  localparam int unsigned AW = $clog2(LEAVES);
  localparam int unsigned IW = AW + 1;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_MUL_GO, ST_MUL_WAIT,
    ST_UPD_RD, ST_UPD_WR, ST_QRY_RD, ST_QRY_ACC, ST_OUT
  } state_e;

  state_e            state_q;
  logic [AW-1:0]     cnt_q;
  logic              qry_q, pass_q;
  logic [IW-1:0]     l_q, r_q, idx_q;
  logic [DATA_W-1:0] v_q, dv1_q, dv2_q, s1_q, s2_q, acc_q;

  logic [IW-1:0]     l_cl, r_cl, lowbit, qry_next;
  logic [IW:0]       upd_next;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  tree_word_t        mem_wdata, mem_rdata;
  logic              mul_start, mul_done;
  logic [DATA_W-1:0] mul_a, mul_p, part;
  logic [IW-1:0]     mul_b;

  function automatic logic [IW-1:0] clamp(input logic [IDX_W-1:0] x);
    logic [31:0] v;
    v = 32'(x);
    if (v == 32'd0) v = 32'd1;
    else if (v > 32'(LEAVES)) v = 32'(LEAVES);
    return IW'(v);
  endfunction

  assign l_cl     = clamp(left_index_i);
  assign r_cl     = clamp(right_index_i);
  assign lowbit   = idx_q & (~idx_q + IW'(1));
  assign upd_next = {1'b0, idx_q} + {1'b0, lowbit};
  assign qry_next = idx_q - lowbit;

  // pick the multiplier index: r or l-1 depending on command and pass
  assign mul_start = (state_q == ST_MUL_GO);
  assign mul_a     = qry_q ? s1_q : v_q;
  assign mul_b     = (qry_q ^ pass_q) ? r_q : l_q - IW'(1);
  assign part      = mul_p - s2_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q[AW-1:0];
    mem_wdata = '0;
    if (state_q == ST_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_q;
    end else if (state_q == ST_UPD_WR) begin
      mem_we       = 1'b1;
      mem_wdata.b1 = mem_rdata.b1 + dv1_q;
      mem_wdata.b2 = mem_rdata.b2 + dv2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      cnt_q   <= '0;
      qry_q   <= 1'b0;
      pass_q  <= 1'b0;
      l_q     <= '0;
      r_q     <= '0;
      idx_q   <= '0;
      v_q     <= '0;
      dv1_q   <= '0;
      dv2_q   <= '0;
      s1_q    <= '0;
      s2_q    <= '0;
      acc_q   <= '0;
    end else begin
      unique case (state_q)
        ST_CLR: begin
          cnt_q <= cnt_q + AW'(1);
          if (cnt_q == AW'(LEAVES - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            l_q    <= l_cl;
            r_q    <= r_cl;
            v_q    <= addend_i;
            pass_q <= 1'b0;
            s1_q   <= '0;
            s2_q   <= '0;
            idx_q  <= r_cl;
            unique case (command_i)
              CMD_CLEAR: begin
                cnt_q   <= '0;
                state_q <= ST_CLR;
              end
              CMD_ADD: begin
                qry_q <= 1'b0;
                if (l_cl <= r_cl) state_q <= ST_MUL_GO;
              end
              CMD_SUM: begin
                qry_q <= 1'b1;
                acc_q <= '0;
                state_q <= (l_cl <= r_cl) ? ST_QRY_RD : ST_OUT;
              end
              default: ;
            endcase
          end
        end
        ST_MUL_GO: state_q <= ST_MUL_WAIT;
        ST_MUL_WAIT: begin
          if (mul_done) begin
            if (!qry_q) begin
              if (!pass_q) begin
                dv1_q   <= v_q;
                dv2_q   <= mul_p;
                idx_q   <= l_q;
                state_q <= ST_UPD_RD;
              end else begin
                dv1_q <= -v_q;
                dv2_q <= -mul_p;
                idx_q <= r_q + IW'(1);
                state_q <= (r_q != IW'(LEAVES)) ? ST_UPD_RD : ST_IDLE;
              end
            end else if (!pass_q) begin
              acc_q <= part;
              s1_q  <= '0;
              s2_q  <= '0;
              idx_q <= l_q - IW'(1);
              if (l_q != IW'(1)) begin
                pass_q  <= 1'b1;
                state_q <= ST_QRY_RD;
              end else begin
                state_q <= ST_OUT;
              end
            end else begin
              acc_q   <= acc_q - part;
              state_q <= ST_OUT;
            end
          end
        end
        ST_UPD_RD: state_q <= ST_UPD_WR;
        ST_UPD_WR: begin
          if (upd_next <= (IW+1)'(LEAVES)) begin
            idx_q   <= upd_next[IW-1:0];
            state_q <= ST_UPD_RD;
          end else if (!pass_q) begin
            pass_q  <= 1'b1;
            state_q <= ST_MUL_GO;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_QRY_RD: state_q <= ST_QRY_ACC;
        ST_QRY_ACC: begin
          s1_q  <= s1_q + mem_rdata.b1;
          s2_q  <= s2_q + mem_rdata.b2;
          idx_q <= qry_next;
          state_q <= (qry_next == '0) ? ST_MUL_GO : ST_QRY_RD;
        end
        ST_OUT: begin
          if (out_ready_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  lstras_mem #(.AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  lstras_mul #(.BW(IW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign range_sum_o = acc_q;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives random and directed add, query, clear and no-op commands into the range-add /
// range-sum tree and checks every query against an element-array predictor.
// ----------------------------------------------------------------------------
module testbench
  import lstras_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NELEM     = LEAVES_DEF;
  localparam int unsigned WDOG_MAX  = 20000;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic [DATA_W-1:0] val;
  } tree_cmd_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [CMD_W-1:0]  command_i = CMD_NOP;
  logic [IDX_W-1:0]  left_index_i = '0;
  logic [IDX_W-1:0]  right_index_i = '0;
  logic [DATA_W-1:0] addend_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [DATA_W-1:0] range_sum_o;

  lazy_segment_tree_range_add_sum uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [DATA_W-1:0] elem_val [1:NELEM];
  tree_cmd_t         cmd_q [$];
  logic [DATA_W-1:0] sum_q [$];
  int                mismatches = 0;
  int                wdog = 0;
  int                send_gap = 0;
  int                recv_gap = 0;
  bit                gaps_on = 1'b1;
  bit                hold_send = 1'b0;
  bit                all_queued = 1'b0;

  function automatic int unsigned clamp_idx(logic [IDX_W-1:0] x);
    if (x < 1) return 1;
    if (x > NELEM) return NELEM;
    return 32'(x);
  endfunction

  // applies one accepted beat to the element array, gives the expected sum for a query
  function automatic bit apply_cmd(tree_cmd_t c, output logic [DATA_W-1:0] sum);
    int unsigned a, b;
    a = clamp_idx(c.lo);
    b = clamp_idx(c.hi);
    sum = '0;
    case (c.cmd)
      CMD_CLEAR: begin
        for (int i = 1; i <= NELEM; i++) elem_val[i] = '0;
        return 1'b0;
      end
      CMD_ADD: begin
        for (int i = a; i <= b; i++) elem_val[i] += c.val;
        return 1'b0;
      end
      CMD_SUM: begin
        for (int i = a; i <= b; i++) sum += elem_val[i];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    logic [DATA_W-1:0] s;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (apply_cmd({command_i, left_index_i, right_index_i, addend_i}, s))
          sum_q.push_back(s);
        wdog <= 0;
      end else if (!(out_valid_o && out_ready_i)) begin
        wdog <= wdog + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (cmd_q.size() > 0 && !hold_send) begin
          in_valid_i <= 1'b1;
          {command_i, left_index_i, right_index_i, addend_i} <= cmd_q.pop_front();
          if (gaps_on && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 9);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (sum_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected sum beat %h", range_sum_o);
        end else if (sum_q[0] !== range_sum_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sum mismatch: expected %h actual %h", sum_q[0], range_sum_o);
          void'(sum_q.pop_front());
        end else begin
          void'(sum_q.pop_front());
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        recv_gap <= $urandom_range(0, 8);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic tree_cmd_t rand_cmd();
    tree_cmd_t c;
    int unsigned r, a, w;
    r = $urandom_range(0, 99);
    w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 40);
    a = $urandom_range(1, 1024);
    c.lo = IDX_W'(a);
    c.hi = IDX_W'(a + w);
    if ($urandom_range(0, 15) == 0) c.lo = IDX_W'($urandom);
    if ($urandom_range(0, 15) == 0) c.hi = IDX_W'($urandom);
    c.val = {$urandom, $urandom};
    if ($urandom_range(0, 1)) c.val = DATA_W'($signed($urandom_range(0, 200)) - 100);
    if (r < 2) c.cmd = CMD_CLEAR;
    else if (r < 4) c.cmd = CMD_NOP;
    else if (r < 50) c.cmd = CMD_ADD;
    else c.cmd = CMD_SUM;
    return c;
  endfunction

  initial begin
    for (int i = 1; i <= NELEM; i++) elem_val[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: load a few points, extremes, empty and clamped ranges
    cmd_q.push_back('{CMD_SUM, 11'd1, 11'd1024, 64'd0});
    cmd_q.push_back('{CMD_ADD, 11'd1, 11'd1, 64'h7fff_ffff_ffff_ffff});
    cmd_q.push_back('{CMD_ADD, 11'd1024, 11'd1024, 64'h8000_0000_0000_0000});
    cmd_q.push_back('{CMD_ADD, 11'd0, 11'h7ff, 64'hffff_ffff_ffff_ffff});
    cmd_q.push_back('{CMD_ADD, 11'd7, 11'd3, 64'd55});
    cmd_q.push_back('{CMD_ADD, 11'd300, 11'd700, 64'h0123_4567_89ab_cdef});
    cmd_q.push_back('{CMD_SUM, 11'd1, 11'd1, '1});
    cmd_q.push_back('{CMD_SUM, 11'd1024, 11'd1024, 64'd0});
    cmd_q.push_back('{CMD_SUM, 11'd0, 11'h7ff, 64'd0});
    cmd_q.push_back('{CMD_SUM, 11'd9, 11'd2, 64'd0});
    cmd_q.push_back('{CMD_SUM, 11'd299, 11'd512, 64'd0});
    cmd_q.push_back('{CMD_SUM, 11'd513, 11'd701, 64'd0});
    cmd_q.push_back('{CMD_NOP, 11'h7ff, 11'h7ff, '1});
    cmd_q.push_back('{CMD_SUM, 11'd1025, 11'd2047, 64'd0});
    cmd_q.push_back('{CMD_CLEAR, 11'd5, 11'd9, '1});
    cmd_q.push_back('{CMD_SUM, 11'd1, 11'd1024, 64'd0});
    for (int i = 0; i < 200; i++) cmd_q.push_back(rand_cmd());
    wait (cmd_q.size() == 0 && !in_valid_i);
    // let the block drain fully before more beats
    hold_send = 1'b1;
    wait (sum_q.size() == 0);
    hold_send = 1'b0;
    for (int i = 0; i < 140; i++) cmd_q.push_back(rand_cmd());
    wait (cmd_q.size() == 0);
    gaps_on = 1'b0;
    for (int i = 0; i < 60; i++) cmd_q.push_back(rand_cmd());
    all_queued = 1'b1;
  end

  initial begin
    wait (all_queued && cmd_q.size() == 0 && !in_valid_i && sum_q.size() == 0);
    repeat (2200) @(posedge clk_i);
    if (mismatches == 0 && sum_q.size() == 0)
      $display("** lazy_segment_tree_range_add_sum: PASSED **");
    else
      $display("** lazy_segment_tree_range_add_sum: FAILED **");
    $finish;
  end

  initial begin
    wait (wdog >= WDOG_MAX);
    $display("** lazy_segment_tree_range_add_sum: FAILED **");
    $finish;
  end
endmodule
